// ===== hw/rtl/bpq_pkg.sv =====
`timescale 1ns / 1ps

package bpq_pkg;

  // Command codes on in_command. The unused code behaves as a peek.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;

  // Result status codes on out_status.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int CODE_W  = 32;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 5;
  localparam int ENTRY_W = CODE_W + PRIO_W;

  // Configuration register map.
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_PRIO_LIMIT = 3'd0;
  localparam logic signed [PRIO_W-1:0] PRIO_LIMIT_RESET = 16'sd10;

endpackage

// ===== hw/rtl/bpq_ram.sv =====
`timescale 1ns / 1ps

module bpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bpq_seq.sv =====
`timescale 1ns / 1ps

module bpq_seq #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [bpq_pkg::PRIO_W-1:0]  prio_limit,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_command,
  input  logic signed [bpq_pkg::CODE_W-1:0]  in_item_code,
  input  logic signed [bpq_pkg::PRIO_W-1:0]  in_item_priority,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic signed [bpq_pkg::CODE_W-1:0]  out_head_code,
  output logic signed [bpq_pkg::PRIO_W-1:0]  out_head_priority,
  output logic [bpq_pkg::COUNT_W-1:0]        out_entry_count,
  output logic [$clog2(DEPTH+1)-1:0]         entry_cnt
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = bpq_pkg::ENTRY_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HEAD  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_PLACE = 2'd3;

  logic [1:0]                        state_r, state_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [AW-1:0]                     head_r, head_nxt;
  logic [AW-1:0]                     k_r, k_nxt;
  logic signed [bpq_pkg::CODE_W-1:0] code_r, code_nxt;
  logic signed [bpq_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic                              rm_r, rm_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_status_r, out_status_nxt;
  logic signed [bpq_pkg::CODE_W-1:0] out_code_r, out_code_nxt;
  logic signed [bpq_pkg::PRIO_W-1:0] out_prio_r, out_prio_nxt;
  logic [bpq_pkg::COUNT_W-1:0]       out_count_r;

  logic                              wr_en, rd_en;
  logic [AW-1:0]                     wr_addr, rd_addr;
  logic [DW-1:0]                     wr_data, rd_data;

  logic signed [bpq_pkg::PRIO_W-1:0] rd_prio;
  logic signed [bpq_pkg::CODE_W-1:0] rd_code;
  logic signed [bpq_pkg::PRIO_W-1:0] cmp_a, cmp_b;
  logic                              cmp_ge;
  logic [CW-1:0]                     cnt_m1;
  logic [AW-1:0]                     last_idx;

  // Logical position to physical slot in the circular entry store.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  bpq_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_prio  = rd_data[DW-1:bpq_pkg::CODE_W];
  assign rd_code  = rd_data[bpq_pkg::CODE_W-1:0];
  assign cnt_m1   = cnt_r - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];

  // One signed comparator serves both the limit check and the sorted scan.
  assign cmp_a  = (state_r == S_IDLE) ? in_item_priority : rd_prio;
  assign cmp_b  = (state_r == S_IDLE) ? prio_limit : prio_r;
  assign cmp_ge = (cmp_a >= cmp_b);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    k_nxt          = k_r;
    code_nxt       = code_r;
    prio_nxt       = prio_r;
    rm_nxt         = rm_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_code_nxt   = out_code_r;
    out_prio_nxt   = out_prio_r;
    wr_en          = 1'b0;
    wr_addr        = phys(head_r, k_r + AW'(1));
    wr_data        = {prio_r, code_r};
    rd_en          = 1'b0;
    rd_addr        = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          code_nxt = in_item_code;
          prio_nxt = in_item_priority;
          rm_nxt   = (in_command == bpq_pkg::CMD_REMOVE);
          if (in_command == bpq_pkg::CMD_INSERT) begin
            out_code_nxt = in_item_code;
            out_prio_nxt = in_item_priority;
            if (cmp_ge) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = bpq_pkg::ST_REJECTED;
            end else if (cnt_r == CW'(DEPTH)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = bpq_pkg::ST_FULL;
            end else if (cnt_r == '0) begin
              wr_en          = 1'b1;
              wr_addr        = head_r;
              wr_data        = {in_item_priority, in_item_code};
              cnt_nxt        = cnt_r + CW'(1);
              out_valid_nxt  = 1'b1;
              out_status_nxt = bpq_pkg::ST_OK;
            end else begin
              // Walk from the tail toward the head, one entry per cycle.
              rd_en     = 1'b1;
              rd_addr   = phys(head_r, last_idx);
              k_nxt     = last_idx;
              state_nxt = S_SCAN;
            end
          end else if (cnt_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bpq_pkg::ST_EMPTY;
            out_code_nxt   = '0;
            out_prio_nxt   = '0;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            state_nxt = S_HEAD;
          end
        end
      end

      S_HEAD: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = bpq_pkg::ST_OK;
        out_code_nxt   = rd_code;
        out_prio_nxt   = rd_prio;
        if (rm_r) begin
          head_nxt = phys(head_r, AW'(1));
          cnt_nxt  = cnt_m1;
        end
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        wr_en = 1'b1;
        if (cmp_ge) begin
          // Entry k stays ahead of the new one; the new entry lands behind it.
          cnt_nxt        = cnt_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = bpq_pkg::ST_OK;
          out_code_nxt   = code_r;
          out_prio_nxt   = prio_r;
          state_nxt      = S_IDLE;
        end else begin
          wr_data = rd_data;
          if (k_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            k_nxt   = k_r - AW'(1);
            rd_en   = 1'b1;
            rd_addr = phys(head_r, k_r - AW'(1));
          end
        end
      end

      S_PLACE: begin
        wr_en          = 1'b1;
        wr_addr        = head_r;
        cnt_nxt        = cnt_r + CW'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = bpq_pkg::ST_OK;
        out_code_nxt   = code_r;
        out_prio_nxt   = prio_r;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    code_r       <= code_nxt;
    prio_r       <= prio_nxt;
    rm_r         <= rm_nxt;
    out_status_r <= out_status_nxt;
    out_code_r   <= out_code_nxt;
    out_prio_r   <= out_prio_nxt;
    if (out_valid_nxt) begin
      out_count_r <= bpq_pkg::COUNT_W'(cnt_nxt);
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_head_code     = out_code_r;
  assign out_head_priority = out_prio_r;
  assign out_entry_count   = out_count_r;
  assign entry_cnt         = cnt_r;

endmodule

// ===== hw/rtl/bounded_priority_queue_top.sv =====
`timescale 1ns / 1ps

// Priority queue of up to DEPTH entries (code, priority), highest priority
// first; equal priorities are served in arrival order.
// Input: a command beat is taken on a rising edge with start high and busy
// low. Insert, remove head and peek head each produce exactly one result.
// Output: each result is shown for one cycle with out_valid high; the
// receiver cannot stall, so it must take every beat as it appears.
// A rejected, full or empty case, or an insert into an empty queue,
// strobes its result the cycle after acceptance and never raises busy.
// Remove and peek raise busy while the head is read from memory.
// An insert walks the sorted store from the tail with one shared comparator,
// one entry per cycle, moving each held entry of lower priority back by one
// slot while busy is high. The result follows in the cycle after the walk, and a new
// command may be started in that same cycle.
// The entry store is a single-port-read, single-port-write RAM used as a
// circular buffer, so removal only advances the head pointer.
// Reset empties the queue at once (no clearing pass) and sets the priority
// limit, register 0 of the APB port, to 10.
module bounded_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpq_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_command,
  input  logic signed [bpq_pkg::CODE_W-1:0] in_item_code,
  input  logic signed [bpq_pkg::PRIO_W-1:0] in_item_priority,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [bpq_pkg::CODE_W-1:0] out_head_code,
  output logic signed [bpq_pkg::PRIO_W-1:0] out_head_priority,
  output logic [bpq_pkg::COUNT_W-1:0]       out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [bpq_pkg::PRIO_W-1:0] limit_r;
  logic                              limit_sel;
  logic                              cfg_wr;
  logic [CW-1:0]                     entry_cnt;

  // Only paddr[2] is decoded: offsets 0 to 3 all reach the limit; offsets 4 to 7 read as zero.
  assign limit_sel = (paddr[bpq_pkg::ADDR_W-1] == bpq_pkg::REG_PRIO_LIMIT[bpq_pkg::ADDR_W-1]);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = limit_sel ? {16'b0, limit_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= bpq_pkg::PRIO_LIMIT_RESET;
    end else if (cfg_wr && limit_sel) begin
      limit_r <= pwdata[bpq_pkg::PRIO_W-1:0];
    end
  end

  bpq_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .prio_limit       (limit_r),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_item_code     (in_item_code),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_code    (out_head_code),
    .out_head_priority(out_head_priority),
    .out_entry_count  (out_entry_count),
    .entry_cnt        (entry_cnt)
  );

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_cnt <= CW'(DEPTH))
    else $error("entry count exceeds queue depth");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result strobe without a command in progress");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == bpq_pkg::CMD_INSERT && in_item_priority >= limit_r)
    |=> (out_valid && out_status == bpq_pkg::ST_REJECTED))
    else $error("insert at or above the limit was not rejected");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command != bpq_pkg::CMD_INSERT && entry_cnt == '0)
    |=> (out_valid && out_status == bpq_pkg::ST_EMPTY && out_entry_count == '0))
    else $error("read of an empty queue not reported as empty");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bpq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CLK_PERIOD = 8;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES = 6;
  // The fourth command code has no name in the package; the block treats it as a peek.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [1:0]                 command;
    logic signed [CODE_W-1:0]   code;
    logic signed [PRIO_W-1:0]   prio;
  } command_beat_t;

  typedef struct {
    logic [1:0]                 status;
    logic signed [CODE_W-1:0]   code;
    logic signed [PRIO_W-1:0]   prio;
    logic [COUNT_W-1:0]         count;
  } queue_result_t;

  typedef struct {
    logic signed [CODE_W-1:0]   code;
    logic signed [PRIO_W-1:0]   prio;
  } held_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = CMD_PEEK;
  logic signed [CODE_W-1:0] in_item_code = '0;
  logic signed [PRIO_W-1:0] in_item_priority = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [CODE_W-1:0] out_head_code;
  logic signed [PRIO_W-1:0] out_head_priority;
  logic [COUNT_W-1:0] out_entry_count;

  command_beat_t pending_cmds[$];
  queue_result_t due_results[$];
  held_entry_t held_entries[$];
  logic signed [PRIO_W-1:0] prio_limit = PRIO_LIMIT_RESET;
  logic signed [PRIO_W-1:0] phase_limit = PRIO_LIMIT_RESET;

  int queued_count = 0;
  int accepted_count = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_left = 0;
  int burst_left = 0;
  int insert_pct = 50;
  bit no_idle = 1'b0;
  logic in_taken = 1'b0;
  command_beat_t next_beat;
  command_beat_t seen_beat;
  queue_result_t want_res;

  bounded_priority_queue_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_item_code     (in_item_code),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_code    (out_head_code),
    .out_head_priority(out_head_priority),
    .out_entry_count  (out_entry_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sorted store, highest priority first. A new entry goes behind every entry of
  // equal or higher priority, so ties leave in arrival order.
  function automatic queue_result_t apply_command(command_beat_t c);
    queue_result_t r;
    held_entry_t e;
    int pos;
    r.status = ST_OK;
    r.code = c.code;
    r.prio = c.prio;
    if (c.command == CMD_INSERT) begin
      if (c.prio >= prio_limit) begin
        r.status = ST_REJECTED;
      end else if (held_entries.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio >= c.prio) pos++;
        e.code = c.code;
        e.prio = c.prio;
        held_entries.insert(pos, e);
      end
    end else if (held_entries.size() == 0) begin
      r.status = ST_EMPTY;
      r.code = '0;
      r.prio = '0;
    end else begin
      r.code = held_entries[0].code;
      r.prio = held_entries[0].prio;
      if (c.command == CMD_REMOVE) void'(held_entries.pop_front());
    end
    r.count = COUNT_W'(held_entries.size());
    return r;
  endfunction

  function automatic int draw_idle();
    if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic push_cmd(input logic [1:0] command, input logic signed [CODE_W-1:0] code,
                          input logic signed [PRIO_W-1:0] prio);
    command_beat_t c;
    c.command = command;
    c.code = code;
    c.prio = prio;
    pending_cmds.push_back(c);
    queued_count++;
  endtask

  // Bursts with a varying insert share walk the queue between empty and full.
  task automatic push_random();
    int p;
    int roll;
    logic [1:0] command;
    logic signed [CODE_W-1:0] code;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 48);
      case ($urandom_range(0, 3))
        0: insert_pct = 25;
        1: insert_pct = 50;
        2: insert_pct = 75;
        default: insert_pct = 90;
      endcase
    end
    burst_left--;
    if ($urandom_range(0, 99) < insert_pct) begin
      command = CMD_INSERT;
    end else begin
      roll = $urandom_range(0, 9);
      command = (roll < 6) ? CMD_REMOVE : (roll < 9) ? CMD_PEEK : CMD_SPARE;
    end
    if ($urandom_range(0, 15) == 0) code = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    else code = $urandom();
    case ($urandom_range(0, 3))
      0: p = int'($urandom_range(0, 65535)) - 32768;
      1: p = int'($urandom_range(0, 8)) - 4;
      2: p = int'(phase_limit) + 1 - int'($urandom_range(0, 3));
      default: p = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    push_cmd(command, code, PRIO_W'(p));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (accepted_count != queued_count || due_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic signed [PRIO_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_PRIO_LIMIT;
    pwdata <= {{(32 - PRIO_W){value[PRIO_W-1]}}, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_taken) begin
      if (start) idle_left = draw_idle();
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_beat = pending_cmds.pop_front();
        start <= 1'b1;
        in_command <= next_beat.command;
        in_item_code <= next_beat.code;
        in_item_priority <= next_beat.prio;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      held_entries.delete();
      prio_limit = PRIO_LIMIT_RESET;
      in_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: status %0d code %0d priority %0d count %0d",
                     out_status, out_head_code, out_head_priority, out_entry_count);
        end else begin
          want_res = due_results.pop_front();
          if (out_status !== want_res.status || out_head_code !== want_res.code ||
              out_head_priority !== want_res.prio || out_entry_count !== want_res.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected status %0d code %0d priority %0d count %0d, %s",
                       want_res.status, want_res.code, want_res.prio, want_res.count,
                       $sformatf("got status %0d code %0d priority %0d count %0d",
                                 out_status, out_head_code, out_head_priority,
                                 out_entry_count));
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == REG_PRIO_LIMIT)
        prio_limit = pwdata[PRIO_W-1:0];
      if (start && !busy) begin
        seen_beat.command = in_command;
        seen_beat.code = in_item_code;
        seen_beat.prio = in_item_priority;
        due_results.push_back(apply_command(seen_beat));
        accepted_count++;
      end
      in_taken <= start && !busy;
      if (out_valid || (start && !busy) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("bounded_priority_queue_top test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue for every read command, then the limit and its neighbors.
    push_cmd(CMD_PEEK, 32'sd5, 16'sd1);
    push_cmd(CMD_REMOVE, 32'sd6, 16'sd2);
    push_cmd(CMD_SPARE, 32'sd7, 16'sd3);
    push_cmd(CMD_INSERT, 32'sd1, PRIO_LIMIT_RESET);
    push_cmd(CMD_INSERT, 32'sh7FFFFFFF, 16'sh7FFF);
    push_cmd(CMD_INSERT, 32'sh80000000, 16'sh8000);
    push_cmd(CMD_INSERT, 32'sh7FFFFFFF, PRIO_LIMIT_RESET - 16'sd1);
    push_cmd(CMD_INSERT, -32'sd1, PRIO_LIMIT_RESET - 16'sd1);
    push_cmd(CMD_INSERT, 32'sd0, 16'sd0);
    // Fill to capacity with many equal priorities.
    for (int fill = 0; fill < DEPTH - 4; fill++)
      push_cmd(CMD_INSERT, CODE_W'(fill * 32'h01010101), PRIO_W'(fill % 5 - 3));
    push_cmd(CMD_INSERT, 32'sd42, 16'sd5);
    // On a full queue the limit check still comes first.
    push_cmd(CMD_INSERT, 32'sd43, PRIO_LIMIT_RESET);
    push_cmd(CMD_PEEK, 32'sd0, 16'sd0);
    push_cmd(CMD_SPARE, 32'sd0, 16'sd0);
    push_cmd(CMD_REMOVE, 32'sd0, 16'sd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1: phase_limit = 16'sh7FFF;
          2: phase_limit = 16'sh8000;
          3: phase_limit = PRIO_W'($urandom_range(0, 65535));
          4: phase_limit = '0;
          default: phase_limit = PRIO_LIMIT_RESET;
        endcase
        write_limit(phase_limit);
        @(posedge clk);
      end
      // With the lowest limit every insert bounces, so that phase stays short.
      for (int n = 0; n < ((ph == 2) ? 60 : 288); n++) push_random();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("bounded_priority_queue_top test passed");
    end else begin
      $display("bounded_priority_queue_top test failed");
    end
    $finish;
  end

endmodule
